/* rtl/core/crc32iv_pkg.sv */
// Package: CRC-32 constants, byte lookup table and word fold function.
`timescale 1ns / 1ps
`default_nettype none

package crc32iv_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int unsigned TABLE_DEPTH = 1 << BYTE_W;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef logic [WORD_W-1:0] t_crc_table [TABLE_DEPTH];

    // Build the reflected byte table at elaboration.
    function automatic t_crc_table crc_build_table();
        t_crc_table tbl;
        logic [WORD_W-1:0] c;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            c = WORD_W'(i);
            for (int k = 0; k < BYTE_W; k++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = crc_build_table();

    // Fold four bytes, least significant first, one table step per byte.
    function automatic logic [WORD_W-1:0] crc_fold_word(
        input logic [WORD_W-1:0] crc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] c;
        logic [BYTE_W-1:0] idx;
        c = crc;
        for (int b = 0; b < BYTES_PER_WORD; b++) begin
            idx = c[BYTE_W-1:0] ^ word[b*BYTE_W +: BYTE_W];
            c = (c >> BYTE_W) ^ CRC_TABLE[idx];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/crc32iv_if.sv */
// Interfaces: image word request channel and check result channel.
`timescale 1ns / 1ps
`default_nettype none

interface crc32iv_word_if;
    import crc32iv_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] image_word;
    logic              is_check_word;

    modport source (output valid, output image_word, output is_check_word, input ready);
    modport sink   (input valid, input image_word, input is_check_word, output ready);
endinterface

interface crc32iv_result_if;
    import crc32iv_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] computed_crc;
    logic              crc_matches;

    modport source (output valid, output computed_crc, output crc_matches, input ready);
    modport sink   (input valid, input computed_crc, input crc_matches, output ready);
endinterface

`default_nettype wire

/* rtl/core/crc32_image_verifier_unit.sv */
// Top level: streaming CRC-32 image check over 32-bit words.
//
// Usage:
//   i_req carries image words (image_word, is_check_word) with valid/ready.
//   Data words are folded into a running reflected CRC-32, low byte first.
//   A word with is_check_word set is the stored checksum: it is not folded,
//   it is compared with the inverted CRC, and one result leaves on o_rsp
//   carrying computed_crc and crc_matches. The CRC then restarts at all ones.
//   A check word passes from the input register to the result register and
//   shows on o_rsp once the result register is free.
//   Throughput: one word per cycle while no check word waits; the four byte
//   table steps of a word sit between the input and CRC registers.
//   Reset (i_rst_n low, synchronous) empties both registers and loads the
//   CRC with all ones.
//   Stall: while o_rsp holds a result that is not taken, data words still
//   pass; a second check word waits in the input register, and i_req.ready
//   drops until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module crc32_image_verifier_unit
    import crc32iv_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    crc32iv_word_if.sink      i_req,
    crc32iv_result_if.source  o_rsp
);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_word;
    logic              r_s1_check;
    logic [WORD_W-1:0] r_crc;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_crc;
    logic              r_out_match;

    logic              out_free;
    logic              s1_go;
    logic              in_take;
    logic [WORD_W-1:0] n_crc;
    logic [WORD_W-1:0] crc_inv;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign s1_go    = r_s1_valid && (!r_s1_check || out_free);
    assign in_take  = i_req.valid && i_req.ready;
    assign crc_inv  = ~r_crc;
    assign n_crc    = crc_fold_word(r_crc, r_s1_word);

    assign i_req.ready        = !r_s1_valid || s1_go;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.computed_crc = r_out_crc;
    assign o_rsp.crc_matches  = r_out_match;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go && r_s1_check) begin
                r_out_valid <= 1'b1;
                r_crc       <= CRC_INIT;
            end else begin
                if (o_rsp.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (s1_go) begin
                    r_crc <= n_crc;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word  <= i_req.image_word;
            r_s1_check <= i_req.is_check_word;
        end
        if (s1_go && r_s1_check) begin
            r_out_crc   <= crc_inv;
            r_out_match <= (crc_inv == r_s1_word);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/crc32iv_checker.sv */
// Checker: port-level assertions for the image verifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module crc32iv_checker
    import crc32iv_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_in_check,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [WORD_W-1:0] i_out_crc,
    input wire logic              i_out_match
);

    logic in_take;
    assign in_take = i_in_valid && i_in_ready;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_crc)
            && $stable(i_out_match))
        else $error("result changed or dropped while stalled");

    // Drop any result at reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A check word taken with an empty result register shows as a result on the output.
    a_check_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in_check && !i_out_valid |=> ##1 i_out_valid)
        else $error("check word produced no result");

    // Advance: with the result register free, a request is always accepted.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !$past(in_take && i_in_check) |-> i_in_ready)
        else $error("input stalled with nothing pending");

endmodule

bind crc32_image_verifier_unit crc32iv_checker u_crc32iv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_check  (i_req.is_check_word),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_crc   (o_rsp.computed_crc),
    .i_out_match (o_rsp.crc_matches)
);

`default_nettype wire
